// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define OLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olm assertion failed");

// next-cycle implication
`define OLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olm assertion failed");

`else

`define OLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define OLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/olm_pkg.sv -----
// ----------------------------------------------------------------------------
// olm_pkg
// shared constants for the ordered list move block
// ----------------------------------------------------------------------------
package olm_pkg;

    // payload field widths
    localparam int FIELD_W = 7;
    localparam int OP_W    = 2;

    // default line depth
    localparam int SLOTS_DEF = 64;

    // entry count after reset
    localparam logic [FIELD_W-1:0] COUNT_RESET = 7'd64;

    // opcodes
    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // result status
    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_ERR  = 1'b1;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ENTRY_COUNT = 1'b0;

endpackage

// ----- rtl/core/olm_in_if.sv -----
// ----------------------------------------------------------------------------
// olm_in_if
// request channel: opcode and operands, valid/ready
// ----------------------------------------------------------------------------
interface olm_in_if;
    import olm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic [FIELD_W-1:0]        entry_id;
    logic signed [FIELD_W-1:0] shift_amount;
    logic [FIELD_W-1:0]        read_position;

    modport source (
        output valid,
        output opcode,
        output entry_id,
        output shift_amount,
        output read_position,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  entry_id,
        input  shift_amount,
        input  read_position,
        output ready
    );
endinterface

// ----- rtl/core/olm_out_if.sv -----
// ----------------------------------------------------------------------------
// olm_out_if
// result channel: status and value, valid/ready
// ----------------------------------------------------------------------------
interface olm_out_if;
    import olm_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [FIELD_W-1:0] result_value;

    modport source (
        output valid,
        output status,
        output result_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  result_value,
        output ready
    );
endinterface

// ----- rtl/core/olm_ram.sv -----
// ----------------------------------------------------------------------------
// olm_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module olm_ram #(
    parameter int WIDTH = olm_pkg::FIELD_W,
    parameter int DEPTH = olm_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/olm_seq.sv -----
// ----------------------------------------------------------------------------
// olm_seq
// sequencer: fill sweep, id scan, one-slot-per-cycle shift, read, result reg
// ----------------------------------------------------------------------------
module olm_seq #(
    parameter int SLOTS = olm_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    olm_in_if.sink                          in_ch,
    olm_out_if.source                       out_ch,
    input  logic [olm_pkg::FIELD_W-1:0]     entry_count,
    output logic                            ram_we,
    output logic [$clog2(SLOTS)-1:0]        ram_waddr,
    output logic [$clog2(SLOTS+1)-1:0]      ram_wdata,
    output logic [$clog2(SLOTS)-1:0]        ram_raddr,
    input  logic [$clog2(SLOTS+1)-1:0]      ram_rdata
);
    import olm_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS+1);
    localparam int IW = (LW > FIELD_W) ? LW : FIELD_W;
    localparam int TW = IW + 2;
    localparam int LEN_RESET = (SLOTS < 64) ? SLOTS : 64;

    localparam logic [2:0] S_FILL   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic                      init_fill_reg, init_fill_next;
    logic [AW-1:0]             fill_reg, fill_next;
    logic [LW-1:0]             len_reg, len_next;
    logic [AW-1:0]             cur_reg, cur_next;
    logic [AW-1:0]             last_reg, last_next;
    logic [AW-1:0]             dst_reg, dst_next;
    logic                      fwd_reg, fwd_next;
    logic                      issue_reg, issue_next;
    logic                      wb_valid_reg, wb_valid_next;
    logic [AW-1:0]             wb_addr_reg, wb_addr_next;
    logic                      chk_valid_reg, chk_valid_next;
    logic [AW-1:0]             chk_pos_reg, chk_pos_next;
    logic [FIELD_W-1:0]        id_reg, id_next;
    logic signed [FIELD_W-1:0] off_reg, off_next;
    logic                      res_status_reg, res_status_next;
    logic [FIELD_W-1:0]        res_value_reg, res_value_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_status_reg, out_status_next;
    logic [FIELD_W-1:0]        out_value_reg, out_value_next;

    // shared step unit: walks the cursor one slot up or down
    logic [AW-1:0]     step_sum;
    logic [LW-1:0]     len_m1;
    logic              match;
    logic signed [TW-1:0] tgt;
    logic [AW-1:0]     tgt_idx;
    logic [IW-1:0]     rp_ext;
    logic [IW-1:0]     rp_m1;

    assign step_sum = fwd_reg ? (cur_reg + AW'(1)) : (cur_reg - AW'(1));
    assign len_m1   = len_reg - LW'(1);
    assign match    = (IW'(ram_rdata) == IW'(id_reg));
    assign tgt      = $signed({2'b00, IW'(chk_pos_reg)}) + TW'(1) + TW'(off_reg);
    assign tgt_idx  = AW'(tgt - TW'(1));
    assign rp_ext   = IW'(in_ch.read_position);
    assign rp_m1    = rp_ext - IW'(1);

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.result_value = out_value_reg;

    always_comb
    begin
        state_next      = state_reg;
        init_fill_next  = init_fill_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        dst_next        = dst_reg;
        fwd_next        = fwd_reg;
        issue_next      = issue_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = wb_addr_reg;
        chk_valid_next  = 1'b0;
        chk_pos_next    = chk_pos_reg;
        id_next         = id_reg;
        off_next        = off_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;

        ram_we    = 1'b0;
        ram_waddr = wb_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cur_reg;

        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = LW'(fill_reg) + LW'(1);
                if (fill_reg == AW'(SLOTS - 1))
                begin
                    state_next = init_fill_reg ? S_EMIT : S_IDLE;
                end
                else
                begin
                    fill_next = fill_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    res_status_next = STAT_ERR;
                    res_value_next  = '0;
                    state_next      = S_EMIT;
                    case (in_ch.opcode)
                        OP_INIT:
                        begin
                            res_status_next = STAT_DONE;
                            len_next = (IW'(entry_count) > IW'(SLOTS)) ?
                                       LW'(SLOTS) : LW'(entry_count);
                            fill_next      = '0;
                            init_fill_next = 1'b1;
                            state_next     = S_FILL;
                        end
                        OP_MOVE:
                        begin
                            if (len_reg != '0)
                            begin
                                id_next    = in_ch.entry_id;
                                off_next   = in_ch.shift_amount;
                                cur_next   = '0;
                                fwd_next   = 1'b1;
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        OP_READ:
                        begin
                            ram_raddr = AW'(rp_m1);
                            if ((rp_ext != '0) && (rp_ext <= IW'(len_reg)))
                            begin
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, compared in the next cycle
                if (issue_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_pos_next   = cur_reg;
                    if (LW'(cur_reg) == len_m1)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = step_sum;
                    end
                end
                if (chk_valid_reg && match)
                begin
                    chk_valid_next = 1'b0;
                    if ((tgt < TW'(1)) || (tgt > $signed({2'b00, IW'(len_reg)})))
                    begin
                        res_status_next = STAT_ERR;
                        res_value_next  = '0;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        res_status_next = STAT_DONE;
                        res_value_next  = tgt[FIELD_W-1:0];
                        dst_next        = tgt_idx;
                        fwd_next        = (tgt_idx > chk_pos_reg);
                        last_next       = chk_pos_reg;
                        cur_next        = (tgt_idx > chk_pos_reg) ?
                                          (chk_pos_reg + AW'(1)) : (chk_pos_reg - AW'(1));
                        issue_next      = 1'b1;
                        state_next      = (tgt_idx == chk_pos_reg) ? S_EMIT : S_SHIFT;
                    end
                end
                else if (chk_valid_reg && !issue_reg)
                begin
                    res_status_next = STAT_ERR;
                    res_value_next  = '0;
                    state_next      = S_EMIT;
                end
            end

            S_SHIFT:
            begin
                // read slot cur, write it one place toward src next cycle
                if (issue_reg)
                begin
                    wb_valid_next = 1'b1;
                    wb_addr_next  = last_reg;
                    last_next     = cur_reg;
                    if (cur_reg == dst_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = step_sum;
                    end
                end
                if (wb_valid_reg)
                begin
                    ram_we = 1'b1;
                    if (!issue_reg)
                    begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_reg;
                ram_wdata  = LW'(IW'(id_reg));
                state_next = S_EMIT;
            end

            S_RDWAIT:
            begin
                res_status_next = STAT_DONE;
                res_value_next  = FIELD_W'(IW'(ram_rdata));
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    init_fill_next  = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            init_fill_reg <= 1'b0;
            fill_reg      <= '0;
            len_reg       <= LW'(LEN_RESET);
            issue_reg     <= 1'b0;
            wb_valid_reg  <= 1'b0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_fill_reg <= init_fill_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            issue_reg     <= issue_next;
            wb_valid_reg  <= wb_valid_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        dst_reg        <= dst_next;
        fwd_reg        <= fwd_next;
        wb_addr_reg    <= wb_addr_next;
        chk_pos_reg    <= chk_pos_next;
        id_reg         <= id_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

endmodule

// ----- rtl/core/ordered_list_move_by_offset.sv -----
// ----------------------------------------------------------------------------
// ordered_list_move_by_offset
// ordered line of ids in a ram with init, move-by-offset and positional read
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    opcode, entry_id, shift_amount, read_position
//  out_ch    out  valid / ready    status, result_value
//  apb       in   psel / penable   paddr, pwdata, prdata (entry_count at 0x0)
//
//  at most two words in flight: one in the sequencer, one in the output register
//  in_ch.ready is high only while the sequencer is idle
//  read: address issued on take, data caught in rdwait, result set in emit
//  init: ram rewrite sweep of all SLOTS slots, one slot a cycle
//  move: scan from position 1 to the id, then shift by |shift_amount| slots;
//  the scan and the shift each pass one ram slot per cycle; after reset the
//  ram is swept to 1..SLOTS before any word is taken; a result held in the
//  output register lets one word in, whose result then waits in emit
`include "assert_macros.svh"

module ordered_list_move_by_offset #(
    parameter int SLOTS = olm_pkg::SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    olm_in_if.sink                           in_ch,
    olm_out_if.source                        out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [olm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [olm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [olm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import olm_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS+1);

    // entry_count register, taken by init only
    logic [FIELD_W-1:0] entry_count_reg, entry_count_next;
    logic               apb_wr;
    logic               reg_sel;

    // ram port between the sequencer and the line store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [LW-1:0] ram_rdata;

    // zero-wait apb; bit 2 of the byte address selects the register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_ENTRY_COUNT);
    assign apb_wr  = psel && penable && pwrite;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (apb_wr && reg_sel)
        begin
            entry_count_next = pwdata[FIELD_W-1:0];
        end
    end

    // unused addresses read back zero
    assign prdata = reg_sel ? {{(APB_DATA_W-FIELD_W){1'b0}}, entry_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= COUNT_RESET;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
        end
    end

    // sequencer: scan, shift, fill and result register
    olm_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .entry_count (entry_count_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // line store, one id per slot, position p at address p-1
    olm_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // no ram write while the sequencer waits for a word
    `OLM_ASSERT_IMP(a_idle_no_write, clk, rst_n, in_ch.ready, !ram_we)
    // a taken word leaves the block busy, with in_ch.ready low after the take
    `OLM_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
    // writes stay inside the SLOTS-deep line store
    `OLM_ASSERT_IMP(a_waddr_range, clk, rst_n, ram_we, ({1'b0, ram_waddr} < (AW+1)'(SLOTS)))
    // an error result always carries a zero value
    `OLM_ASSERT_IMP(a_err_zero, clk, rst_n,
        out_ch.valid && (out_ch.status == STAT_ERR), out_ch.result_value == '0)

endmodule
